### sv/darac_pkg.sv
// Shared types and codes of the deadlock-avoiding resource allocator.
package darac_pkg;

   localparam int DEF_NUM_PROCS   = 8;
   localparam int DEF_NUM_RES     = 4;
   localparam int DEF_QUEUE_DEPTH = 16;

   // The result port carries a two-bit resource index.
   localparam int RES_LIMIT = 4;

   localparam int CMD_FIFO_DEPTH = 2;
   localparam int RSP_FIFO_DEPTH = 4;

   localparam logic [2:0] KIND_SET_TOTAL = 3'd0;
   localparam logic [2:0] KIND_SET_CLAIM = 3'd1;
   localparam logic [2:0] KIND_SET_HOLD  = 3'd2;
   localparam logic [2:0] KIND_REQUEST   = 3'd3;
   localparam logic [2:0] KIND_RELEASE   = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_QUEUED  = 2'd1;
   localparam logic [1:0] ST_OVER    = 2'd2;
   localparam logic [1:0] ST_DROPPED = 2'd3;

   localparam logic REG_PROCS = 1'b0;
   localparam logic REG_RES   = 1'b1;

   localparam logic [3:0] PROCS_RESET = 4'd8;
   localparam logic [2:0] RES_RESET   = 3'd4;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] proc_id;
      logic [1:0] res;
      logic [7:0] amount;
   } cmd_hdr_type;

   typedef struct packed {
      logic [1:0] res;
      logic [7:0] avail;
      logic [1:0] status;
      logic       last;
   } rsp_item_type;

endpackage

### sv/darac_fifo.sv
// Small register FIFO used between the allocator stages and at the result side.
module darac_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DEPTH-1:0][WIDTH-1:0] mem_ff;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### sv/darac_front.sv
// Front end: takes transactions, gathers command vectors, filters loads, issues commands.
module darac_front #(
   parameter int NUM_PROCS = 8,
   parameter int NUM_RES   = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [2:0]                     req_type,
   input  logic [2:0]                     req_proc_id,
   input  logic [1:0]                     req_res_index,
   input  logic [7:0]                     req_amount,
   input  logic                           req_last,
   input  logic [$clog2(NUM_PROCS+1)-1:0] eff_p,
   input  logic [2:0]                     eff_r,
   input  logic                           cmd_full,
   output logic                           cmd_push,
   output darac_pkg::cmd_hdr_type         cmd_hdr,
   output logic [NUM_RES-1:0][7:0]        cmd_vec
);
   import darac_pkg::*;

   localparam int CMPW = $clog2(NUM_PROCS + 1) + 3;

   logic [NUM_RES-1:0][7:0] pend_ff, pend_in, pend_nx;
   logic accept, res_ok, proc_ok, is_load, is_vec;

   assign full    = cmd_full;
   assign accept  = push & ~cmd_full;
   assign res_ok  = ({1'b0, req_res_index} < eff_r);
   assign proc_ok = (CMPW'(req_proc_id) < CMPW'(eff_p));
   assign is_load = (req_type <= KIND_SET_HOLD);
   assign is_vec  = (req_type == KIND_REQUEST) || (req_type == KIND_RELEASE);

   always_comb begin
      pend_nx = pend_ff;
      for (int r = 0; r < NUM_RES; r++) begin
         if (res_ok && (int'(req_res_index) == r)) begin
            pend_nx[r] = req_amount;
         end
      end
   end

   always_comb begin
      pend_in  = pend_ff;
      cmd_push = 1'b0;
      if (accept) begin
         priority if (is_load) begin
            cmd_push = res_ok & proc_ok;
         end else if (is_vec) begin
            if (req_last) begin
               cmd_push = 1'b1;
               pend_in  = '0;
            end else begin
               pend_in = pend_nx;
            end
         end
      end
   end

   assign cmd_hdr = '{kind: req_type, proc_id: req_proc_id, res: req_res_index,
                      amount: req_amount};
   assign cmd_vec = pend_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

endmodule

### sv/darac_back.sv
// Back end: sequencer for loads, requests with the safety check, releases and queue retries.
module darac_back #(
   parameter int NUM_PROCS   = 8,
   parameter int NUM_RES     = 4,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [$clog2(NUM_PROCS+1)-1:0] eff_p,
   input  logic [2:0]                     eff_r,
   input  logic                           cmd_valid,
   input  darac_pkg::cmd_hdr_type         cmd_hdr,
   input  logic [NUM_RES-1:0][7:0]        cmd_vec,
   output logic                           cmd_pop,
   output logic                           rsp_push,
   output darac_pkg::rsp_item_type        rsp_item,
   input  logic                           rsp_full
);
   import darac_pkg::*;

   localparam int P_W    = $clog2(NUM_PROCS + 1);
   localparam int PIW    = $clog2(NUM_PROCS);
   localparam int RIW    = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
   localparam int QIW    = $clog2(QUEUE_DEPTH);
   localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
   localparam int ACC_W  = 8 + $clog2(NUM_PROCS);
   localparam int WORK_W = 9 + $clog2(NUM_PROCS);
   localparam int CMPW   = P_W + 3;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_TOTAL     = 4'd1;
   localparam logic [3:0] S_HOLD      = 4'd2;
   localparam logic [3:0] S_CHECK     = 4'd3;
   localparam logic [3:0] S_SAFE_INIT = 4'd4;
   localparam logic [3:0] S_SAFE_ROW  = 4'd5;
   localparam logic [3:0] S_ROLLBACK  = 4'd6;
   localparam logic [3:0] S_FINISH    = 4'd7;
   localparam logic [3:0] S_RELEASE   = 4'd8;
   localparam logic [3:0] S_RD        = 4'd9;
   localparam logic [3:0] S_LOAD      = 4'd10;
   localparam logic [3:0] S_REPORT    = 4'd11;

   logic [3:0] state_ff, state_in;

   logic [NUM_PROCS-1:0][NUM_RES-1:0][7:0] claim_ff, hold_ff;
   logic [NUM_RES-1:0][7:0] free_ff, free_in;

   logic [2:0] cur_kind_ff, cur_kind_in, cur_p_ff, cur_p_in;
   logic [1:0] cur_r_ff, cur_r_in;
   logic [7:0] cur_amt_ff, cur_amt_in;
   logic [NUM_RES-1:0][7:0] cur_vec_ff, cur_vec_in;

   logic [PIW-1:0] row_ff, row_in;
   logic [ACC_W-1:0] acc_ff, acc_in, acc_nx;
   logic [NUM_RES-1:0][WORK_W-1:0] work_ff, work_in;
   logic [NUM_PROCS-1:0] done_ff, done_in, done_nx, in_use;
   logic prog_ff, prog_in, prog_nx;
   logic retry_ff, retry_in;
   logic [1:0] tr_res_ff, tr_res_in, status_ff, status_in;
   logic [QCW-1:0] k_ff, k_in, n_ff, n_in, count_ff, count_in;
   logic [QIW-1:0] head_ff, head_in, tail;
   logic [QIW:0] tail_sum;
   logic [1:0] rep_ff, rep_in;

   logic [2:0] qp_mem [QUEUE_DEPTH];
   logic [NUM_RES-1:0][7:0] qv_mem [QUEUE_DEPTH];
   logic [2:0] rd_p_ff;
   logic [NUM_RES-1:0][7:0] rd_vec_ff;
   logic q_we;

   logic [NUM_RES-1:0][7:0] claim_row, hold_row, hold_wd;
   logic hold_we, claim_we;
   logic [NUM_RES-1:0] res_on, over_v, short_v, fit_v;
   logic [NUM_RES-1:0][7:0] need_v, rel_amt, rel_free;
   logic [8:0] hold_sum;
   logic [7:0] hold_free;
   logic p_bad, over, short_any, fits, row_last, all_done_nx, rep_last;

   assign claim_row = claim_ff[row_ff];
   assign hold_row  = hold_ff[row_ff];
   assign p_bad     = (CMPW'(cur_p_ff) >= CMPW'(eff_p));
   assign row_last  = (P_W'(row_ff) + P_W'(1) == eff_p);
   assign rep_last  = ({1'b0, rep_ff} == eff_r - 3'd1);
   assign tail_sum  = (QIW+1)'(head_ff) + (QIW+1)'(count_ff);
   assign tail      = (tail_sum >= (QIW+1)'(QUEUE_DEPTH)) ?
                      QIW'(tail_sum - (QIW+1)'(QUEUE_DEPTH)) : QIW'(tail_sum);

   // Per-resource compares; every lane is independent.
   always_comb begin
      for (int r = 0; r < NUM_RES; r++) begin
         res_on[r]  = (r < int'(eff_r));
         over_v[r]  = res_on[r] &&
                      ({1'b0, hold_row[r]} + {1'b0, cur_vec_ff[r]} > {1'b0, claim_row[r]});
         short_v[r] = res_on[r] && (cur_vec_ff[r] > free_ff[r]);
         need_v[r]  = (claim_row[r] > hold_row[r]) ? claim_row[r] - hold_row[r] : 8'd0;
         fit_v[r]   = ~res_on[r] || (WORK_W'(need_v[r]) <= work_ff[r]);
         rel_amt[r] = (cur_vec_ff[r] < hold_row[r]) ? cur_vec_ff[r] : hold_row[r];
         rel_free[r] = ({1'b0, free_ff[r]} + {1'b0, rel_amt[r]} > 9'd255) ? 8'd255 :
                       free_ff[r] + rel_amt[r];
      end
   end

   assign over      = |over_v;
   assign short_any = |short_v;

   always_comb begin
      for (int i = 0; i < NUM_PROCS; i++) begin
         in_use[i] = (i < int'(eff_p));
      end
   end

   assign fits = ~done_ff[row_ff] & (&fit_v);

   always_comb begin
      done_nx = done_ff;
      done_nx[row_ff] = done_ff[row_ff] | fits;
   end

   assign prog_nx     = prog_ff | fits;
   assign all_done_nx = &(done_nx | ~in_use);
   assign acc_nx      = acc_ff + ACC_W'(hold_row[RIW'(cur_r_ff)]);
   assign hold_sum    = {1'b0, free_ff[RIW'(cur_r_ff)]} + {1'b0, hold_row[RIW'(cur_r_ff)]};
   assign hold_free   = (hold_sum < {1'b0, cur_amt_ff}) ? 8'd0 :
                        ((hold_sum - {1'b0, cur_amt_ff} > 9'd255) ? 8'd255 :
                         8'(hold_sum - {1'b0, cur_amt_ff}));

   always_comb begin
      state_in    = state_ff;
      free_in     = free_ff;
      cur_kind_in = cur_kind_ff;
      cur_p_in    = cur_p_ff;
      cur_r_in    = cur_r_ff;
      cur_amt_in  = cur_amt_ff;
      cur_vec_in  = cur_vec_ff;
      row_in      = row_ff;
      acc_in      = acc_ff;
      work_in     = work_ff;
      done_in     = done_ff;
      prog_in     = prog_ff;
      retry_in    = retry_ff;
      tr_res_in   = tr_res_ff;
      status_in   = status_ff;
      k_in        = k_ff;
      n_in        = n_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      rep_in      = rep_ff;
      hold_we     = 1'b0;
      hold_wd     = hold_row;
      claim_we    = 1'b0;
      q_we        = 1'b0;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               cur_kind_in = cmd_hdr.kind;
               cur_p_in    = cmd_hdr.proc_id;
               cur_r_in    = cmd_hdr.res;
               cur_amt_in  = cmd_hdr.amount;
               cur_vec_in  = cmd_vec;
               row_in      = PIW'(cmd_hdr.proc_id);
               acc_in      = '0;
               retry_in    = 1'b0;
               unique case (cmd_hdr.kind)
                  KIND_SET_TOTAL: begin
                     row_in   = '0;
                     state_in = S_TOTAL;
                  end
                  KIND_SET_CLAIM: claim_we = 1'b1;
                  KIND_SET_HOLD:  state_in = S_HOLD;
                  KIND_REQUEST:   state_in = S_CHECK;
                  KIND_RELEASE:   state_in = S_RELEASE;
                  default:        state_in = S_IDLE;
               endcase
            end
         end
         S_TOTAL: begin
            acc_in = acc_nx;
            if (row_last) begin
               free_in[RIW'(cur_r_ff)] = (acc_nx >= ACC_W'(cur_amt_ff)) ? 8'd0 :
                                         8'(ACC_W'(cur_amt_ff) - acc_nx);
               state_in = S_IDLE;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         S_HOLD: begin
            free_in[RIW'(cur_r_ff)] = hold_free;
            hold_we = 1'b1;
            hold_wd[RIW'(cur_r_ff)] = cur_amt_ff;
            state_in = S_IDLE;
         end
         S_CHECK: begin
            priority if (p_bad || over) begin
               tr_res_in = ST_OVER;
               state_in  = S_FINISH;
            end else if (short_any) begin
               tr_res_in = ST_QUEUED;
               state_in  = S_FINISH;
            end else begin
               hold_we = 1'b1;
               for (int r = 0; r < NUM_RES; r++) begin
                  if (res_on[r]) begin
                     hold_wd[r] = hold_row[r] + cur_vec_ff[r];
                     free_in[r] = free_ff[r] - cur_vec_ff[r];
                  end
               end
               state_in = S_SAFE_INIT;
            end
         end
         S_SAFE_INIT: begin
            for (int r = 0; r < NUM_RES; r++) begin
               work_in[r] = WORK_W'(free_ff[r]);
            end
            done_in  = '0;
            prog_in  = 1'b0;
            row_in   = '0;
            state_in = S_SAFE_ROW;
         end
         S_SAFE_ROW: begin
            done_in = done_nx;
            prog_in = prog_nx;
            if (fits) begin
               for (int r = 0; r < NUM_RES; r++) begin
                  work_in[r] = work_ff[r] + WORK_W'(hold_row[r]);
               end
            end
            if (row_last) begin
               priority if (all_done_nx) begin
                  tr_res_in = ST_OK;
                  row_in    = PIW'(cur_p_ff);
                  state_in  = S_FINISH;
               end else if (prog_nx) begin
                  row_in  = '0;
                  prog_in = 1'b0;
               end else begin
                  row_in   = PIW'(cur_p_ff);
                  state_in = S_ROLLBACK;
               end
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         S_ROLLBACK: begin
            hold_we = 1'b1;
            for (int r = 0; r < NUM_RES; r++) begin
               if (res_on[r]) begin
                  hold_wd[r] = hold_row[r] - cur_vec_ff[r];
                  free_in[r] = free_ff[r] + cur_vec_ff[r];
               end
            end
            tr_res_in = ST_QUEUED;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (retry_ff) begin
               if (tr_res_ff == ST_QUEUED) begin
                  q_we     = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               k_in = k_ff + 1'b1;
               if (k_ff + 1'b1 == n_ff) begin
                  status_in = ST_OK;
                  rep_in    = '0;
                  state_in  = S_REPORT;
               end else begin
                  state_in = S_RD;
               end
            end else begin
               status_in = tr_res_ff;
               if (tr_res_ff == ST_QUEUED) begin
                  if (count_ff < QCW'(QUEUE_DEPTH)) begin
                     q_we     = 1'b1;
                     count_in = count_ff + 1'b1;
                  end else begin
                     status_in = ST_DROPPED;
                  end
               end
               rep_in   = '0;
               state_in = S_REPORT;
            end
         end
         S_RELEASE: begin
            if (!p_bad) begin
               hold_we = 1'b1;
               for (int r = 0; r < NUM_RES; r++) begin
                  if (res_on[r]) begin
                     hold_wd[r] = hold_row[r] - rel_amt[r];
                     free_in[r] = rel_free[r];
                  end
               end
            end
            retry_in = 1'b1;
            n_in     = count_ff;
            k_in     = '0;
            if (count_ff == '0) begin
               status_in = ST_OK;
               rep_in    = '0;
               state_in  = S_REPORT;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            head_in  = (head_ff == QIW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cur_p_in   = rd_p_ff;
            cur_vec_in = rd_vec_ff;
            row_in     = PIW'(rd_p_ff);
            state_in   = S_CHECK;
         end
         S_REPORT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (rep_last) begin
                  state_in = S_IDLE;
               end else begin
                  rep_in = rep_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_item = '{res: rep_ff, avail: free_ff[RIW'(rep_ff)], status: status_ff,
                       last: rep_last};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_ff  <= '0;
         claim_ff <= '0;
         hold_ff  <= '0;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         if (hold_we) begin
            hold_ff[row_ff] <= hold_wd;
         end
         if (claim_we) begin
            claim_ff[PIW'(cmd_hdr.proc_id)][RIW'(cmd_hdr.res)] <= cmd_hdr.amount;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_kind_ff <= cur_kind_in;
      cur_p_ff    <= cur_p_in;
      cur_r_ff    <= cur_r_in;
      cur_amt_ff  <= cur_amt_in;
      cur_vec_ff  <= cur_vec_in;
      row_ff      <= row_in;
      acc_ff      <= acc_in;
      work_ff     <= work_in;
      done_ff     <= done_in;
      prog_ff     <= prog_in;
      retry_ff    <= retry_in;
      tr_res_ff   <= tr_res_in;
      status_ff   <= status_in;
      k_ff        <= k_in;
      n_ff        <= n_in;
      rep_ff      <= rep_in;
   end

   // Wait queue storage: one write port at the tail, registered read at the head.
   always_ff @(posedge clock) begin
      if (q_we) begin
         qp_mem[tail] <= cur_p_ff;
         qv_mem[tail] <= cur_vec_ff;
      end
      if (state_ff == S_RD) begin
         rd_p_ff   <= qp_mem[head_ff];
         rd_vec_ff <= qv_mem[head_ff];
      end
   end

endmodule

### sv/deadlock_avoiding_resource_allocator_core.sv
// Top level of the deadlock-avoiding resource allocator: register port and stage wiring.
//
// Banker's allocator. Transactions enter through a queue-like port (push/full)
// and carry one resource element each: load elements set a resource total, a
// process claim or a process holding; request and release elements build a vector
// that is executed on the element marked last. Every request or release emits one
// result per resource type in use, giving the free units after the command and a
// status (granted/released, queued, rejected over claim, dropped with the wait
// queue full). A front stage gathers vectors and drops loads for unused processes
// or resources; a two-entry command queue feeds a back-end sequencer that owns
// the claim and holding tables, the free counts and the wait queue. A claim load is
// written from idle, a holding load also updates the free count, and a total load sums
// one row of holdings per cycle. A request is checked against its claim and the free
// units; if it fits it is committed and put through the safety check (up to P passes
// over the P processes in use, one process row per cycle, which sets the rate) and is
// rolled back if unsafe; its results then wait for room in the result queue. A release
// frees units, then reads, loads and fully checks each queued request. The front keeps
// accepting transactions while the back end works, until the command queue fills.
// Configuration registers: procs_in_use at byte 0, res_in_use at byte 4;
// write them only while the block is idle.
module deadlock_avoiding_resource_allocator_core
   import darac_pkg::*;
#(
   parameter int NUM_PROCS   = darac_pkg::DEF_NUM_PROCS,
   parameter int NUM_RES     = darac_pkg::DEF_NUM_RES,
   parameter int QUEUE_DEPTH = darac_pkg::DEF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_proc_id,
   input  logic [1:0]  req_res_index,
   input  logic [7:0]  req_amount,
   input  logic        req_last,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_out_res_index,
   output logic [7:0]  rsp_available_count,
   output logic [1:0]  rsp_status,
   output logic        rsp_out_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int P_W     = $clog2(NUM_PROCS + 1);
   localparam int CMPW    = P_W + 4;
   localparam int RES_CAP = (NUM_RES < RES_LIMIT) ? NUM_RES : RES_LIMIT;
   localparam int CMD_W   = $bits(cmd_hdr_type) + NUM_RES * 8;
   localparam int RSP_W   = $bits(rsp_item_type);

   logic [3:0] procs_ff;
   logic [2:0] res_ff;
   logic [P_W-1:0] eff_p;
   logic [2:0] eff_r;
   logic csr_wr;

   cmd_hdr_type cmd_hdr_w, cmd_hdr_r;
   logic [NUM_RES-1:0][7:0] cmd_vec_w, cmd_vec_r;
   logic cmd_push, cmd_full, cmd_empty, cmd_pop;
   rsp_item_type rsp_w, rsp_r;
   logic rsp_push, rsp_full;

   // Register port: zero wait states, write on the access phase.
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         procs_ff <= PROCS_RESET;
         res_ff   <= RES_RESET;
      end else if (csr_wr) begin
         unique case (paddr[2])
            REG_PROCS: procs_ff <= pwdata[3:0];
            REG_RES:   res_ff   <= pwdata[2:0];
            default:   procs_ff <= procs_ff;
         endcase
      end
   end

   assign prdata = (paddr[2] == REG_RES) ? {29'd0, res_ff} : {28'd0, procs_ff};

   // Clamp both counts: zero acts as one, oversize values act as the maximum.
   always_comb begin
      priority if (procs_ff == 4'd0) begin
         eff_p = P_W'(1);
      end else if (CMPW'(procs_ff) > CMPW'(NUM_PROCS)) begin
         eff_p = P_W'(NUM_PROCS);
      end else begin
         eff_p = P_W'(procs_ff);
      end
      priority if (res_ff == 3'd0) begin
         eff_r = 3'd1;
      end else if (res_ff > 3'(RES_CAP)) begin
         eff_r = 3'(RES_CAP);
      end else begin
         eff_r = res_ff;
      end
   end

   darac_front #(.NUM_PROCS(NUM_PROCS), .NUM_RES(NUM_RES)) u_front (
      .clock, .reset, .push, .full,
      .req_type, .req_proc_id, .req_res_index, .req_amount, .req_last,
      .eff_p, .eff_r, .cmd_full,
      .cmd_push, .cmd_hdr(cmd_hdr_w), .cmd_vec(cmd_vec_w)
   );

   // Hold decoded commands between the stages.
   darac_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_FIFO_DEPTH)) u_cmd_q (
      .clock, .reset, .push(cmd_push), .wr_data({cmd_hdr_w, cmd_vec_w}),
      .full(cmd_full), .pop(cmd_pop), .rd_data({cmd_hdr_r, cmd_vec_r}),
      .empty(cmd_empty)
   );

   darac_back #(.NUM_PROCS(NUM_PROCS), .NUM_RES(NUM_RES),
                .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock, .reset, .eff_p, .eff_r,
      .cmd_valid(~cmd_empty), .cmd_hdr(cmd_hdr_r), .cmd_vec(cmd_vec_r), .cmd_pop,
      .rsp_push, .rsp_item(rsp_w), .rsp_full
   );

   // Result transactions wait here until popped.
   darac_fifo #(.WIDTH(RSP_W), .DEPTH(RSP_FIFO_DEPTH)) u_rsp_q (
      .clock, .reset, .push(rsp_push), .wr_data(rsp_w), .full(rsp_full),
      .pop, .rd_data(rsp_r), .empty
   );

   assign rsp_out_res_index   = rsp_r.res;
   assign rsp_available_count = rsp_r.avail;
   assign rsp_status          = rsp_r.status;
   assign rsp_out_last        = rsp_r.last;

endmodule

### sv/darac_checker.sv
// Port-level checks on the allocator's result reports, bound to the top level.
module darac_checker (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic [1:0] rsp_out_res_index,
   input logic [1:0] rsp_status,
   input logic       rsp_out_last
);

   // Within one report the resource index steps by one.
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !rsp_out_last) |=>
      (empty || rsp_out_res_index == 2'($past(rsp_out_res_index) + 2'd1)))
      else $error("report index did not advance");

   // A new report starts at resource zero.
   a_index_restart: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && rsp_out_last) |=> (empty || rsp_out_res_index == 2'd0))
      else $error("report did not restart at resource zero");

   // All transactions of one report share the status.
   a_status_const: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !rsp_out_last) |=> (empty || rsp_status == $past(rsp_status)))
      else $error("status changed within a report");

   // A waiting result stays until popped.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("waiting result vanished");

endmodule

bind deadlock_avoiding_resource_allocator_core darac_checker u_darac_checker (.*);
